>>> rtl/pgs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pgs_pkg
// Types, constants and the arctangent table shared by the steering pipeline.
// ---------------------------------------------------------------------------
package pgs_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int XW = 34;
	localparam int ZW = 26;
	localparam int HW = 17;
	localparam int AW = 18;

	localparam logic signed [22:0] R2D_Q16 = 23'sd3754938;
	localparam logic signed [19:0] D2R_Q24 = 20'sd292762;
	localparam logic [29:0] CORDIC_K_Q30 = 30'd652032875;
	localparam logic signed [ZW-1:0] QUARTER_Z = 26'sd5898240;
	localparam logic signed [HW-1:0] FULL_TURN = 17'sd46080;
	localparam logic signed [HW-1:0] HALF_TURN = 17'sd23040;

	typedef enum logic [2:0] {
		REG_GOAL_X        = 3'd0,
		REG_GOAL_Y        = 3'd1,
		REG_GOAL_HEADING  = 3'd2,
		REG_GAIN_DISTANCE = 3'd3,
		REG_GAIN_BEARING  = 3'd4,
		REG_GAIN_HEADING  = 3'd5,
		REG_ARRIVE_RADIUS = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [15:0] yaw_rad;
	} pose_t;

	typedef struct packed {
		logic [23:0]        linear_speed;
		logic signed [15:0] angular_rate;
		logic               arrived;
	} cmd_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic signed [HW-1:0] head;
		logic                 zero;
	} cord_t;

	typedef struct packed {
		logic signed [15:0] goal_heading;
		logic [15:0]        gain_distance;
		logic [15:0]        gain_bearing;
		logic [15:0]        gain_heading;
		logic [22:0]        arrive_radius;
	} ctl_cfg_t;

	function automatic logic signed [ZW-1:0] atan_deg16(input int idx);
		case (idx)
			0: return 26'sd2949120;
			1: return 26'sd1740967;
			2: return 26'sd919879;
			3: return 26'sd466945;
			4: return 26'sd234379;
			5: return 26'sd117304;
			6: return 26'sd58666;
			7: return 26'sd29335;
			8: return 26'sd14668;
			9: return 26'sd7334;
			10: return 26'sd3667;
			11: return 26'sd1833;
			12: return 26'sd917;
			13: return 26'sd458;
			14: return 26'sd229;
			15: return 26'sd115;
			16: return 26'sd57;
			17: return 26'sd29;
			18: return 26'sd14;
			19: return 26'sd7;
			20: return 26'sd4;
			21: return 26'sd2;
			22: return 26'sd1;
			default: return '0;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> rtl/pgs_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pgs_cell
// One CORDIC vectoring micro-rotation with its own valid and handshake.
// ---------------------------------------------------------------------------
module pgs_cell import pgs_pkg::*; #(
	parameter int IDX = 0
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire cord_t in_d,
	input  wire logic  rdy_next,
	output logic       rdy,
	output logic       out_valid,
	output cord_t      out_d
);

	logic v_q;
	cord_t d_q;
	cord_t nx;
	logic signed [XW-1:0] xs, ys;

	assign rdy = !v_q || rdy_next;

	always_comb begin
		xs = in_d.x >>> IDX;
		ys = in_d.y >>> IDX;
		nx = in_d;
		if (!in_d.y[XW-1]) begin
			nx.x = in_d.x + ys;
			nx.y = in_d.y - xs;
			nx.z = in_d.z + atan_deg16(IDX);
		end else begin
			nx.x = in_d.x - ys;
			nx.y = in_d.y + xs;
			nx.z = in_d.z - atan_deg16(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && in_valid) begin
			d_q <= nx;
		end
	end

	assign out_valid = v_q;
	assign out_d = d_q;

endmodule
`default_nettype wire

>>> rtl/pgs_tail.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pgs_tail
// Distance scaling, angle errors, gains, rad/s conversion and saturation.
// ---------------------------------------------------------------------------
module pgs_tail import pgs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ctl_cfg_t cfg,
	input  wire logic     in_valid,
	input  wire cord_t    in_d,
	output logic          rdy,
	output logic          cmd_valid,
	input  wire logic     cmd_stall,
	output cmd_t          cmd
);

	logic v1, v2, v3, v4, v5;
	logic r1, r2, r3, r4, r5;

	logic [46:0] ph_s1;
	logic [45:0] pl_s1;
	logic signed [AW-1:0] alpha_s1, beta_s1;

	logic [26:0] dist_s2;
	logic signed [34:0] pa_s2, pb_s2;

	logic arr_s3;
	logic [42:0] vp_s3;
	logic signed [38:0] s_s3;

	logic arr_s4;
	logic [23:0] v_s4;
	logic signed [57:0] wp_s4;

	cmd_t cmd_s5;

	logic [32:0] xc;
	logic signed [ZW-1:0] zr;
	logic signed [AW-1:0] bear;
	logic [63:0] dsum;
	logic [27:0] vr;
	logic signed [57:0] wsum;
	logic signed [22:0] wr;

	assign r5 = !v5 || !cmd_stall;
	assign r4 = !v4 || r5;
	assign r3 = !v3 || r4;
	assign r2 = !v2 || r3;
	assign r1 = !v1 || r2;
	assign rdy = r1;

	always_comb begin
		xc = in_d.x[XW-1] ? '0 : in_d.x[XW-2:0];
		zr = (in_d.z + 26'sd256) >>> 9;
		bear = in_d.zero ? '0 : AW'(zr);
		dsum = {1'b0, ph_s1, 16'd0} + {18'd0, pl_s1} + (64'd1 << 35);
		vr = 28'((vp_s3 + 43'd32768) >> 16);
		wsum = (wp_s4 + (58'sd1 <<< 34)) >>> 35;
		wr = 23'(wsum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
		end else begin
			if (r1) v1 <= in_valid;
			if (r2) v2 <= v1;
			if (r3) v3 <= v2;
			if (r4) v4 <= v3;
			if (r5) v5 <= v4;
		end
	end

	always_ff @(posedge clk) begin
		if (r1 && in_valid) begin
			ph_s1 <= 47'(xc[32:16]) * 47'(CORDIC_K_Q30);
			pl_s1 <= 46'(xc[15:0]) * 46'(CORDIC_K_Q30);
			alpha_s1 <= bear - AW'(in_d.head);
			beta_s1 <= AW'(cfg.goal_heading) - AW'(in_d.head);
		end
		if (r2 && v1) begin
			dist_s2 <= 27'(dsum >> 36);
			pa_s2 <= 35'(signed'({1'b0, cfg.gain_bearing})) * 35'(alpha_s1);
			pb_s2 <= 35'(signed'({1'b0, cfg.gain_heading})) * 35'(beta_s1);
		end
		if (r3 && v2) begin
			arr_s3 <= dist_s2 < {4'd0, cfg.arrive_radius};
			vp_s3 <= 43'(cfg.gain_distance) * 43'(dist_s2);
			if (dist_s2 < {4'd0, cfg.arrive_radius}) begin
				s_s3 <= 39'(pb_s2) * 39'sd10;
			end else begin
				s_s3 <= 39'(pa_s2) + 39'(pb_s2);
			end
		end
		if (r4 && v3) begin
			arr_s4 <= arr_s3;
			v_s4 <= (vr > 28'd16777215) ? 24'hFFFFFF : vr[23:0];
			wp_s4 <= 58'(s_s3) * 58'(D2R_Q24);
		end
		if (r5 && v4) begin
			cmd_s5.linear_speed <= v_s4;
			cmd_s5.arrived <= arr_s4;
			if (wr > 23'sd32767) begin
				cmd_s5.angular_rate <= 16'sh7FFF;
			end else if (wr < -23'sd32768) begin
				cmd_s5.angular_rate <= 16'sh8000;
			end else begin
				cmd_s5.angular_rate <= wr[15:0];
			end
		end
	end

	assign cmd_valid = v5;
	assign cmd = cmd_s5;

endmodule
`default_nettype wire

>>> rtl/polar_go_to_goal_steering.sv
`default_nettype none
// ---------------------------------------------------------------------------
// polar_go_to_goal_steering
// Go-to-goal polar steering: pose in, speed and turn-rate command out.
//
// A pose transfers on pose when pose_valid is high and pose_stall is low;
// a command transfers on cmd when cmd_valid is high and cmd_stall is low.
// Each pose yields exactly one command, in order.
// The datapath has two front stages (difference vector, yaw scaling, heading
// wrap and quadrant pre-rotation), one cell per CORDIC micro-rotation, and
// five back stages (distance scaling, gains, rad/s conversion, saturation,
// output register).
// Throughput is one pose per cycle while cmd_stall is low; every stage holds
// its own valid bit, so a stalled output only backs up the stages that are
// occupied and empty stages keep accepting poses.
// Reset clears all valid bits and loads the default goal and gains.
// Write the goal and gain registers over cfg_we/cfg_index/cfg_data only while
// no pose is in flight; an unused index is ignored.
// ---------------------------------------------------------------------------
module polar_go_to_goal_steering import pgs_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pose_valid,
	output logic             pose_stall,
	input  wire pose_t       pose,
	output logic             cmd_valid,
	input  wire logic        cmd_stall,
	output cmd_t             cmd,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	logic signed [23:0] goal_x_q, goal_y_q;
	ctl_cfg_t cfg_q;

	logic v_s0, v_s1, rdy_s0, rdy_s1;
	logic signed [24:0] dx_s0, dy_s0;
	logic signed [37:0] yprod_s0;
	cord_t d_s1;

	logic signed [37:0] hround;
	logic signed [HW-1:0] h, hw;
	logic signed [XW-1:0] xx, yy;
	cord_t pre;

	logic cv [0:CORDIC_STAGES];
	logic crdy [0:CORDIC_STAGES];
	cord_t cd [0:CORDIC_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= 24'sd131072;
			goal_y_q <= 24'sd131072;
			cfg_q.goal_heading <= 16'sd11520;
			cfg_q.gain_distance <= 16'd655;
			cfg_q.gain_bearing <= 16'd3277;
			cfg_q.gain_heading <= 16'd328;
			cfg_q.arrive_radius <= 23'd3277;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GOAL_X:        goal_x_q <= cfg_data;
				REG_GOAL_Y:        goal_y_q <= cfg_data;
				REG_GOAL_HEADING:  cfg_q.goal_heading <= cfg_data[15:0];
				REG_GAIN_DISTANCE: cfg_q.gain_distance <= cfg_data[15:0];
				REG_GAIN_BEARING:  cfg_q.gain_bearing <= cfg_data[15:0];
				REG_GAIN_HEADING:  cfg_q.gain_heading <= cfg_data[15:0];
				REG_ARRIVE_RADIUS: cfg_q.arrive_radius <= cfg_data[22:0];
				default: ;
			endcase
		end
	end

	assign rdy_s0 = !v_s0 || rdy_s1;
	assign rdy_s1 = !v_s1 || crdy[0];
	assign pose_stall = !rdy_s0;

	always_comb begin
		hround = (yprod_s0 + 38'sd1048576) >>> 21;
		h = HW'(hround);
		if (h > HALF_TURN) begin
			hw = h - FULL_TURN;
		end else if (h <= -HALF_TURN) begin
			hw = h + FULL_TURN;
		end else begin
			hw = h;
		end
		xx = XW'(dx_s0) <<< 6;
		yy = XW'(dy_s0) <<< 6;
		pre.x = xx;
		pre.y = yy;
		pre.z = '0;
		pre.head = hw;
		pre.zero = (dx_s0 == '0) && (dy_s0 == '0);
		if (dx_s0[24]) begin
			if (!dy_s0[24]) begin
				pre.x = yy;
				pre.y = -xx;
				pre.z = QUARTER_Z;
			end else begin
				pre.x = -yy;
				pre.y = xx;
				pre.z = -QUARTER_Z;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
		end else begin
			if (rdy_s0) v_s0 <= pose_valid;
			if (rdy_s1) v_s1 <= v_s0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s0 && pose_valid) begin
			dx_s0 <= 25'(goal_x_q) - 25'(pose.pos_x);
			dy_s0 <= 25'(goal_y_q) - 25'(pose.pos_y);
			yprod_s0 <= 38'(pose.yaw_rad) * 38'(R2D_Q16);
		end
		if (rdy_s1 && v_s0) begin
			d_s1 <= pre;
		end
	end

	assign cv[0] = v_s1;
	assign cd[0] = d_s1;

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
		pgs_cell #(.IDX(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (cv[k]),
			.in_d     (cd[k]),
			.rdy_next (crdy[k+1]),
			.rdy      (crdy[k]),
			.out_valid(cv[k+1]),
			.out_d    (cd[k+1])
		);
	end

	pgs_tail u_tail (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (cv[CORDIC_STAGES]),
		.in_d     (cd[CORDIC_STAGES]),
		.rdy      (crdy[CORDIC_STAGES]),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd)
	);

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		pose_stall |-> (v_s0 && v_s1))
		else $error("pose stalled with a free front stage");
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(pose_valid && !pose_stall) |=> v_s0)
		else $error("accepted pose lost at front stage");
	a_front_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !crdy[0]) |=> (v_s1 && $stable(d_s1)))
		else $error("blocked front stage changed");

endmodule
`default_nettype wire
